// ===== rtl/afu_pkg.sv =====
// shared types, codes and elaboration-time rom builder for the activation unit
// no dependencies; used by activation_function_unit_top
package afu_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned SAMPLE_W = 17;  // q16 sample, 0 to 65536 inclusive
  localparam int unsigned KIND_W   = 2;

  localparam logic [SAMPLE_W-1:0] Q16_ONE = SAMPLE_W'(65536);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [SAMPLE_W-1:0]      sample_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOGISTIC = 2'd0,
    KIND_TANH     = 2'd1,
    KIND_RELU     = 2'd2
  } kind_e;

  // request control that travels down the pipeline
  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic               deriv;
    data_t              x;
  } ctl_t;

  // shift-subtract divide, only ever evaluated while elaborating
  function automatic longint unsigned afu_udiv(longint unsigned num,
                                               longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    int              b;
    q = 0;
    r = 0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // logistic of m steps above zero, q16, from a q24 exponential of one step
  function automatic longint unsigned afu_pos_half(longint unsigned step,
                                                   longint unsigned m);
    longint unsigned one;
    longint unsigned term;
    longint unsigned ed;
    longint unsigned g;
    longint unsigned k;
    one  = 64'd1 << 24;
    term = one;
    ed   = one;
    g    = one;
    for (k = 1; k <= 24; k++) begin
      term = afu_udiv((term * step) >> 24, k);
      ed   = ed + term;
    end
    for (k = 1; k <= m; k++) begin
      g = (g * ed + (one >> 1)) >> 24;
    end
    return afu_udiv((g << 16) + ((g + one) >> 1), g + one);
  endfunction

  // rom sample i of n+1 points spread over [-8, 8]
  function automatic longint unsigned afu_rom_sample(longint unsigned n,
                                                     longint unsigned step,
                                                     longint unsigned i);
    longint unsigned res;
    if (2 * i >= n) begin
      res = afu_pos_half(step, 2 * i - n);
    end else begin
      res = 64'd65536 - afu_pos_half(step, n - 2 * i);
    end
    return res;
  endfunction

endpackage

// ===== rtl/activation_function_unit_top.sv =====
// activation unit: logistic, tanh and relu with derivatives, fixed point
// depends on afu_pkg (types, kind codes, rom builder)
//
//  channel   handshake                  payload
//  input     start, busy                x_i, want_derivative_i
//  result    done_o (one-cycle strobe)  y_o
//  config    cfg_valid_i, cfg_ready_o   cfg_data_i (function kind)
//
// one request accepted per cycle while busy is low, one result strobe per request
// the pipeline includes the rom lookup, the interpolation multiply and the
// derivative multiply, each with its own register stage
// busy is high only during reset and the first cycle after it
// the pipeline never stalls; results cannot be held off
// the function kind is captured with each request
module activation_function_unit_top #(
  parameter int unsigned FRAC_BITS     = 10,
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  afu_pkg::data_t         x_i,
  input  logic                   want_derivative_i,
  output logic                   done_o,
  output afu_pkg::data_t         y_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [afu_pkg::KIND_W-1:0] cfg_data_i
);
  import afu_pkg::*;

  localparam int unsigned IW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RW   = FRAC_BITS + 4;       // log2 of the input span
  localparam int unsigned NUMW = RW + IW;
  localparam int unsigned ZW   = (FRAC_BITS + 5 > 17) ? FRAC_BITS + 5 : 17;
  localparam int unsigned PW   = SAMPLE_W + RW;
  localparam int unsigned MW   = 2 * SAMPLE_W;
  localparam longint unsigned RomStep = (64'd8 << 24) / TABLE_ENTRIES;
  localparam logic signed [ZW-1:0] LIM = ZW'(longint'(8) << FRAC_BITS);
  localparam data_t MINUS_ONE = data_t'(-(longint'(1) << FRAC_BITS));

  // sample rom, built at elaboration
  sample_t rom_w [TABLE_ENTRIES+1];
  for (genvar gi = 0; gi <= TABLE_ENTRIES; gi++) begin : g_rom
    localparam sample_t Sample = SAMPLE_W'(afu_rom_sample(
        longint'(TABLE_ENTRIES), RomStep, longint'(gi)));
    assign rom_w[gi] = Sample;
  end

  logic [KIND_W-1:0] kind_q, kind_d;
  logic              busy_q, busy_d;
  logic              accept;

  ctl_t ctl1_q, ctl1_d, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;

  // stage 1: input offset and index
  logic              sat_lo1_q, sat_lo1_d, sat_hi1_q, sat_hi1_d;
  logic [IW-1:0]     idx1_q, idx1_d;
  logic [RW-1:0]     rem1_q, rem1_d;
  // stage 2: rom read
  logic              sat_lo2_q, sat_hi2_q, neg2_q, neg2_d;
  sample_t           lo2_q, lo2_d, diff2_q, diff2_d;
  logic [RW-1:0]     rem2_q;
  // stage 3: interpolation product
  logic              sat_lo3_q, sat_hi3_q, neg3_q;
  sample_t           lo3_q;
  logic [PW-1:0]     prod3_q, prod3_d;
  // stage 4: logistic value
  sample_t           s4_q, s4_d;
  // stage 5: multiplier operands
  sample_t           s5_q, a5_q, a5_d, b5_q, b5_d;
  // stage 6: derivative product
  sample_t           s6_q;
  logic [MW-1:0]     p6_q, p6_d;
  // stage 7: output
  data_t             y_q, y_d;
  logic              done_q;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;
  assign busy_d      = 1'b0;
  assign kind_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : kind_q;

  always_comb begin
    logic signed [ZW-1:0] x_ext;
    logic signed [ZW-1:0] z;
    logic signed [ZW-1:0] u_full;
    logic [NUMW-1:0]      num;
    logic [IW-1:0]        idx_raw;
    x_ext  = ZW'(x_i);
    z      = (kind_q == KIND_TANH) ? (x_ext <<< 1) : x_ext;
    sat_lo1_d = (z <= -LIM);
    sat_hi1_d = (z >= LIM);
    u_full = z + LIM;
    num    = NUMW'(u_full[RW-1:0]) * NUMW'(TABLE_ENTRIES);
    idx_raw = num[NUMW-1:RW];
    rem1_d  = num[RW-1:0];
    idx1_d  = (idx_raw >= IW'(TABLE_ENTRIES)) ? IW'(TABLE_ENTRIES - 1) : idx_raw;
    ctl1_d.valid = accept;
    ctl1_d.kind  = kind_q;
    ctl1_d.deriv = want_derivative_i;
    ctl1_d.x     = x_i;
  end

  always_comb begin
    sample_t hi;
    lo2_d   = rom_w[idx1_q];
    hi      = rom_w[idx1_q + IW'(1)];
    neg2_d  = (hi < lo2_d);
    diff2_d = hi - lo2_d;
  end

  assign prod3_d = PW'(diff2_q) * PW'(rem2_q);

  always_comb begin
    sample_t interp;
    logic [PW-1:0] rounded;
    rounded = (prod3_q + PW'(longint'(1) << (RW - 1))) >> RW;
    interp  = lo3_q + rounded[SAMPLE_W-1:0];
    if (sat_lo3_q) begin
      s4_d = '0;
    end else if (sat_hi3_q) begin
      s4_d = Q16_ONE;
    end else if (neg3_q) begin
      s4_d = lo3_q;
    end else begin
      s4_d = interp;
    end
  end

  always_comb begin
    logic [SAMPLE_W:0] t_off;
    sample_t           mag;
    t_off = {s4_q, 1'b0};
    if (t_off >= {1'b0, Q16_ONE}) begin
      mag = SAMPLE_W'(t_off - {1'b0, Q16_ONE});
    end else begin
      mag = SAMPLE_W'({1'b0, Q16_ONE} - t_off);
    end
    if (ctl4_q.kind == KIND_TANH) begin
      a5_d = mag;
      b5_d = mag;
    end else begin
      a5_d = s4_q;
      b5_d = Q16_ONE - s4_q;
    end
  end

  assign p6_d = MW'(a5_q) * MW'(b5_q);

  always_comb begin
    logic [SAMPLE_W:0]   s_rnd;
    logic [SAMPLE_W+1:0] t_rnd;
    logic [MW-1:0]       p_rnd;
    logic [MW-1:0]       q_rnd;
    s_rnd = ({1'b0, s6_q} + (SAMPLE_W+1)'(longint'(1) << (15 - FRAC_BITS)))
            >> (16 - FRAC_BITS);
    t_rnd = ({1'b0, s6_q, 1'b0} + (SAMPLE_W+2)'(longint'(1) << (15 - FRAC_BITS)))
            >> (16 - FRAC_BITS);
    p_rnd = (p6_q + MW'(longint'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    q_rnd = ((MW'(longint'(1) << 32) - p6_q) + MW'(longint'(1) << (31 - FRAC_BITS)))
            >> (32 - FRAC_BITS);
    case (ctl6_q.kind)
      KIND_LOGISTIC: y_d = ctl6_q.deriv ? data_t'(p_rnd[DATA_W-1:0])
                                        : data_t'(s_rnd[DATA_W-1:0]);
      KIND_TANH: begin
        if (ctl6_q.deriv) begin
          y_d = data_t'(q_rnd[DATA_W-1:0]);
        end else begin
          y_d = data_t'(t_rnd[DATA_W-1:0]) + MINUS_ONE;
        end
      end
      KIND_RELU: begin
        if (ctl6_q.deriv) begin
          y_d = (ctl6_q.x > 0) ? data_t'(longint'(1) << FRAC_BITS) : '0;
        end else begin
          y_d = (ctl6_q.x < 0) ? '0 : ctl6_q.x;
        end
      end
      default: y_d = '0;
    endcase
  end

  // control: valid bits and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_LOGISTIC;
      busy_q <= 1'b1;
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
      done_q <= 1'b0;
    end else begin
      kind_q <= kind_d;
      busy_q <= busy_d;
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
      done_q <= ctl6_q.valid;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    sat_lo1_q <= sat_lo1_d;
    sat_hi1_q <= sat_hi1_d;
    idx1_q    <= idx1_d;
    rem1_q    <= rem1_d;
    sat_lo2_q <= sat_lo1_q;
    sat_hi2_q <= sat_hi1_q;
    neg2_q    <= neg2_d;
    lo2_q     <= lo2_d;
    diff2_q   <= diff2_d;
    rem2_q    <= rem1_q;
    sat_lo3_q <= sat_lo2_q;
    sat_hi3_q <= sat_hi2_q;
    neg3_q    <= neg2_q;
    lo3_q     <= lo2_q;
    prod3_q   <= prod3_d;
    s4_q      <= s4_d;
    s5_q      <= s4_q;
    a5_q      <= a5_d;
    b5_q      <= b5_d;
    s6_q      <= s5_q;
    p6_q      <= p6_d;
    y_q       <= y_d;
  end

  assign done_o = done_q;
  assign y_o    = y_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 done_o)
    else $error("request did not produce a result after seven cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 7))
    else $error("result strobe without a matching request");

  a_logistic_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl4_q.valid |-> s4_q <= Q16_ONE)
    else $error("interpolated logistic above one");

  a_deriv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl6_q.valid && (ctl6_q.kind == KIND_TANH) |-> p6_q <= MW'(longint'(1) << 32))
    else $error("tanh square exceeds one");

  a_result_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> y_o >= MINUS_ONE)
    else $error("result below minus one");
`endif

endmodule
